FILE: hdl/b64u_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b64u_pkg
// Shared types, constants and the symbol table of the base64url encoder.
// ----------------------------------------------------------------------------
package b64u_pkg;

  localparam int unsigned BYTE_W      = 8;
  localparam int unsigned CHAR_W      = 7;
  localparam int unsigned SYM_W       = 6;
  localparam int unsigned GROUP_W     = 3 * BYTE_W;
  localparam int unsigned QUEUE_DEPTH = 2;

  // One three-byte group on its way from the front to the back. Missing
  // bytes of a short group are already zero here.
  typedef struct packed {
    logic [GROUP_W-1:0] word;
    logic               last;
  } group_t;

  typedef logic [CHAR_W-1:0] char_t;

  // URL-safe alphabet: A-Z a-z 0-9 - _
  function automatic char_t sym_to_char(input logic [SYM_W-1:0] sym);
    char_t ch;
    if (sym < 6'd26) begin
      ch = 7'h41 + {1'b0, sym};
    end else if (sym < 6'd52) begin
      ch = 7'h61 + {1'b0, sym - 6'd26};
    end else if (sym < 6'd62) begin
      ch = 7'h30 + {1'b0, sym - 6'd52};
    end else if (sym == 6'd62) begin
      ch = 7'h2D;
    end else begin
      ch = 7'h5F;
    end
    return ch;
  endfunction

endpackage

FILE: hdl/base64url_byte_encoder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// base64url_byte_encoder
// Byte stream to URL-safe base64 characters, short final group padded
// with 'A'; the last character of a message carries tlast.
// ----------------------------------------------------------------------------
// Path: the byte that closes a group writes it into the queue, from which
// it moves to the back's current-group register and then the output stage.
// Throughput: one byte per cycle in unless the queue is full, one char per
// cycle out unless m_tready stalls; the single-character output port sets
// the sustained pace; the queue lets input run QUEUE_DEPTH groups ahead.
// Reset: synchronous; clears the held bytes, the queue and the output stage.
module base64url_byte_encoder #(
  parameter int unsigned QUEUE_DEPTH = b64u_pkg::QUEUE_DEPTH
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        s_tvalid,
  output logic                        s_tready,
  input  logic [b64u_pkg::BYTE_W-1:0] s_tdata,  // [7:0] data_byte
  input  logic                        s_tlast,  // is_last
  output logic                        m_tvalid,
  input  logic                        m_tready,
  output logic [b64u_pkg::BYTE_W-1:0] m_tdata,  // [6:0] code_char, [7] zero
  output logic                        m_tlast   // final_char
);

  logic             push;
  b64u_pkg::group_t push_group;
  logic             queue_full;
  logic             pop;
  logic             queue_valid;
  b64u_pkg::group_t head;

  b64u_front u_front (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .s_tlast    (s_tlast),
    .push       (push),
    .push_group (push_group),
    .queue_full (queue_full)
  );

  b64u_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_group (push_group),
    .full       (queue_full),
    .pop        (pop),
    .not_empty  (queue_valid),
    .head       (head)
  );

  b64u_back u_back (
    .clk         (clk),
    .rst         (rst),
    .group_valid (queue_valid),
    .group_in    (head),
    .pop         (pop),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata),
    .m_tlast     (m_tlast)
  );

endmodule

FILE: hdl/b64u_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b64u_front
// Accepts bytes, gathers them into groups of three and hands each closed
// group (full, or short and closed by the last byte) to the queue.
// ----------------------------------------------------------------------------
module b64u_front (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       s_tvalid,
  output logic                       s_tready,
  input  logic [b64u_pkg::BYTE_W-1:0] s_tdata,  // [7:0] data_byte
  input  logic                       s_tlast,   // is_last
  output logic                       push,
  output b64u_pkg::group_t           push_group,
  input  logic                       queue_full
);

  logic [2*b64u_pkg::BYTE_W-1:0] pending;
  logic [1:0]                    count;
  logic                          accept;

  assign s_tready = !queue_full;
  assign accept   = s_tvalid && s_tready;

  always_comb begin
    push_group.last = s_tlast;
    push            = 1'b0;
    unique case (count)
      2'd2: begin
        push_group.word = {pending, s_tdata};
        push            = accept;
      end
      2'd1: begin
        push_group.word = {pending[2*b64u_pkg::BYTE_W-1 -: b64u_pkg::BYTE_W], s_tdata,
                           {b64u_pkg::BYTE_W{1'b0}}};
        push            = accept && s_tlast;
      end
      default: begin
        // A count of zero, and the unreachable count of three, start a new group.
        push_group.word = {s_tdata, {2*b64u_pkg::BYTE_W{1'b0}}};
        push            = accept && s_tlast;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= 2'd0;
    end else if (accept) begin
      if (push) begin
        count <= 2'd0;
      end else if (count == 2'd1) begin
        count <= 2'd2;
      end else begin
        count <= 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      if (count == 2'd1) begin
        pending[b64u_pkg::BYTE_W-1:0] <= s_tdata;
      end else begin
        pending <= {s_tdata, {b64u_pkg::BYTE_W{1'b0}}};
      end
    end
  end

endmodule

FILE: hdl/b64u_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b64u_queue
// Short first-in first-out queue of closed groups between front and back.
// ----------------------------------------------------------------------------
module b64u_queue #(
  parameter int unsigned DEPTH = b64u_pkg::QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  b64u_pkg::group_t push_group,
  output logic             full,
  input  logic             pop,
  output logic             not_empty,
  output b64u_pkg::group_t head
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  b64u_pkg::group_t entries [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] fill;
  logic             do_push;
  logic             do_pop;

  assign full      = (fill == FULL_CNT);
  assign not_empty = (fill != '0);
  assign head      = entries[rd_ptr];
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        fill <= fill + 1'b1;
      end else if (do_pop && !do_push) begin
        fill <= fill - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_group;
    end
  end

endmodule

FILE: hdl/b64u_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b64u_back
// Takes one group at a time and sends its four characters, high six bits
// first, through a registered output stage.
// ----------------------------------------------------------------------------
module b64u_back (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        group_valid,
  input  b64u_pkg::group_t            group_in,
  output logic                        pop,
  output logic                        m_tvalid,
  input  logic                        m_tready,
  output logic [b64u_pkg::BYTE_W-1:0] m_tdata,  // [6:0] code_char, [7] zero
  output logic                        m_tlast   // final_char
);

  b64u_pkg::group_t           cur;
  logic                       busy;
  logic [1:0]                 idx;
  logic                       out_free;
  logic [b64u_pkg::SYM_W-1:0] sym;

  assign out_free = !m_tvalid || m_tready;
  // Refill when idle, or as the fourth character of the current group is registered.
  assign pop      = group_valid && (!busy || (out_free && idx == 2'd3));

  always_comb begin
    unique case (idx)
      2'd0:    sym = cur.word[23:18];
      2'd1:    sym = cur.word[17:12];
      2'd2:    sym = cur.word[11:6];
      default: sym = cur.word[5:0];
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy     <= 1'b0;
      idx      <= 2'd0;
      m_tvalid <= 1'b0;
    end else begin
      if (out_free) begin
        m_tvalid <= busy;
      end
      if (pop) begin
        busy <= 1'b1;
        idx  <= 2'd0;
      end else if (out_free && busy) begin
        idx <= idx + 2'd1;
        if (idx == 2'd3) begin
          busy <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cur <= group_in;
    end
    if (out_free && busy) begin
      m_tdata <= {1'b0, b64u_pkg::sym_to_char(sym)};
      m_tlast <= cur.last && (idx == 2'd3);
    end
  end

endmodule
